/* rtl/core/rrse_pkg.sv */
// Shared types and constants for the rectangle region set engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rrse_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    localparam logic [2:0] OP_REPLACE  = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_SUBTRACT = 3'd2;
    localparam logic [2:0] OP_INTERSECT = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam logic [2:0] OP_BOUNDS   = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;
    localparam logic [2:0] OP_MOVE     = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] bound_left;
        logic signed [15:0] bound_top;
        logic [15:0]        bound_width;
        logic [15:0]        bound_height;
        logic [6:0]         region_count;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_en;
        logic rd_bank;
    } t_store_ctl;

endpackage

`default_nettype wire

/* rtl/core/rect_region_set_engine.sv */
// Replace, add and clear pass through the single-write state and then the
// finish state; the list operations read, evaluate and put each stored
// region in turn, and subtract puts up to four pieces per region. One item
// at a time; the next item is accepted as soon as the sequencer returns to
// idle, even while the result waits. Reset clears the region count, the
// active bank select and the overflow flag; the region stores are not cleared.
`default_nettype none

module rect_region_set_engine #(
    parameter int MAX_REGIONS = rrse_pkg::MAX_REGIONS_DEF,
    parameter int COORD_BITS  = rrse_pkg::COORD_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire rrse_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output rrse_pkg::t_out_item      o_out_item
);
    import rrse_pkg::*;

    localparam int EW    = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int AW    = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int DW    = 2 * EW + 30;

    localparam logic signed [EW-1:0] C_MAX = EW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] C_MIN = -C_MAX - EW'(1);
    localparam logic signed [EW-1:0] S16_MAX = EW'(32767);
    localparam logic signed [EW-1:0] S16_MIN = -EW'(32768);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_REGIONS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SINGLE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    function automatic logic signed [EW-1:0] sat(input logic signed [EW-1:0] v);
        sat = (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
    endfunction

    logic [2:0]           r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic signed [EW-1:0] r_px, n_px, r_py, n_py, r_rx, n_rx, r_ry, n_ry;
    logic [14:0]          r_rw, n_rw, r_rh, n_rh;
    logic [CNT_W-1:0]     r_count, n_count, r_n, n_n, r_idx, n_idx;
    logic                 r_act, n_act, r_flag, n_flag, r_hit, n_hit;
    logic [1:0]           r_pc, n_pc;
    logic signed [EW-1:0] r_gx, n_gx, r_gy, n_gy;
    logic [14:0]          r_gw, n_gw, r_gh, n_gh;
    logic signed [EW-1:0] r_gr, n_gr, r_gb, n_gb;
    logic signed [EW-1:0] r_il, n_il, r_it, n_it, r_ir, n_ir, r_ib, n_ib;
    logic                 r_ov, n_ov, r_ins, n_ins;
    logic signed [EW-1:0] r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    t_out_item            r_out, n_out;
    logic                 r_ovalid, n_ovalid;

    t_store_ctl           st_ctl;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [DW-1:0]        wr_data, rd_data;

    logic signed [EW-1:0] g_x, g_y, e_gr, e_gb, e_il, e_it, e_ir, e_ib;
    logic [14:0]          g_w, g_h;
    logic                 e_ov, e_ins;

    // put request from the list loop into the other bank
    logic                 put_req;
    logic signed [EW-1:0] put_x, put_y;
    logic [14:0]          put_w, put_h;
    logic                 step_done;
    logic signed [EW-1:0] pos_x_e, pos_y_e;
    logic signed [EW:0]   bdx, bdy;
    logic                 out_free;

    assign {g_x, g_y, g_w, g_h} = rd_data;

    rrse_geom #(.EW(EW)) u_geom (
        .i_gx(g_x), .i_gy(g_y), .i_gw(g_w), .i_gh(g_h),
        .i_rx(r_rx), .i_ry(r_ry), .i_rw(r_rw), .i_rh(r_rh),
        .i_px(r_px), .i_py(r_py),
        .o_gr(e_gr), .o_gb(e_gb), .o_il(e_il), .o_it(e_it),
        .o_ir(e_ir), .o_ib(e_ib), .o_ov(e_ov), .o_inside(e_ins)
    );

    rrse_store #(.DEPTH(MAX_REGIONS), .DW(DW)) u_store (
        .i_clk(i_clk), .i_ctl(st_ctl),
        .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign pos_x_e     = EW'(i_in_item.pos_x);
    assign pos_y_e     = EW'(i_in_item.pos_y);

    // piece selection for the list loop
    always_comb begin
        put_req   = 1'b0;
        put_x     = r_gx;
        put_y     = r_gy;
        put_w     = r_gw;
        put_h     = r_gh;
        step_done = 1'b1;
        case (r_op)
            OP_SUBTRACT: begin
                if (!r_ov) begin
                    put_req = 1'b1;
                end else begin
                    step_done = (r_pc == 2'd3);
                    case (r_pc)
                        2'd0: begin
                            put_req = (r_il > r_gx);
                            put_w   = 15'(r_il - r_gx);
                        end
                        2'd1: begin
                            put_req = (r_ir < r_gr);
                            put_x   = r_ir;
                            put_w   = 15'(r_gr - r_ir);
                        end
                        2'd2: begin
                            put_req = (r_it > r_gy);
                            put_x   = r_il;
                            put_w   = 15'(r_ir - r_il);
                            put_h   = 15'(r_it - r_gy);
                        end
                        default: begin
                            put_req = (r_ib < r_gb);
                            put_x   = r_il;
                            put_y   = r_ib;
                            put_w   = 15'(r_ir - r_il);
                            put_h   = 15'(r_gb - r_ib);
                        end
                    endcase
                end
            end
            OP_INTERSECT: begin
                put_req = r_ov;
                put_x   = r_il;
                put_y   = r_it;
                put_w   = 15'(r_ir - r_il);
                put_h   = 15'(r_ib - r_it);
            end
            default: begin
                put_req = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;  n_op = r_op;
        n_px = r_px;  n_py = r_py;  n_rx = r_rx;  n_ry = r_ry;
        n_rw = r_rw;  n_rh = r_rh;
        n_count = r_count;  n_n = r_n;  n_idx = r_idx;
        n_act = r_act;  n_flag = r_flag;  n_hit = r_hit;  n_pc = r_pc;
        n_gx = r_gx;  n_gy = r_gy;  n_gw = r_gw;  n_gh = r_gh;
        n_gr = r_gr;  n_gb = r_gb;
        n_il = r_il;  n_it = r_it;  n_ir = r_ir;  n_ib = r_ib;
        n_ov = r_ov;  n_ins = r_ins;
        n_x0 = r_x0;  n_y0 = r_y0;  n_x1 = r_x1;  n_y1 = r_y1;
        n_out = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        st_ctl = '0;
        wr_addr = r_idx[AW-1:0];
        rd_addr = r_idx[AW-1:0];
        wr_data = {r_rx, r_ry, r_rw, r_rh};
        bdx = '0;
        bdy = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_item.op;
                    n_px  = pos_x_e;
                    n_py  = pos_y_e;
                    n_rx  = sat(pos_x_e);
                    n_ry  = sat(pos_y_e);
                    n_rw  = i_in_item.size_w;
                    n_rh  = i_in_item.size_h;
                    n_idx = '0;
                    n_n   = '0;
                    n_pc  = '0;
                    n_hit = 1'b0;
                    if (i_in_item.op == OP_REPLACE || i_in_item.op == OP_ADD ||
                        i_in_item.op == OP_CLEAR) begin
                        n_state = S_SINGLE;
                    end else if (r_count == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SINGLE: begin
                st_ctl.wr_bank = r_act;
                case (r_op)
                    OP_REPLACE: begin
                        st_ctl.wr_en = 1'b1;
                        wr_addr = '0;
                        n_count = CNT_W'(1);
                    end
                    OP_ADD: begin
                        if (r_count >= MAX_C) begin
                            n_flag = 1'b1;
                        end else begin
                            st_ctl.wr_en = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    default: begin
                        n_count = '0;
                    end
                endcase
                n_state = S_FIN;
            end
            S_READ: begin
                st_ctl.rd_en   = 1'b1;
                st_ctl.rd_bank = r_act;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_gx = g_x;  n_gy = g_y;  n_gw = g_w;  n_gh = g_h;
                n_gr = e_gr; n_gb = e_gb;
                n_il = e_il; n_it = e_it; n_ir = e_ir; n_ib = e_ib;
                n_ov = e_ov; n_ins = e_ins;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (put_req) begin
                    if (r_n >= MAX_C) begin
                        n_flag = 1'b1;
                    end else begin
                        st_ctl.wr_en   = 1'b1;
                        st_ctl.wr_bank = !r_act;
                        wr_addr = r_n[AW-1:0];
                        wr_data = {put_x, put_y, put_w, put_h};
                        n_n = r_n + CNT_W'(1);
                    end
                end
                case (r_op)
                    OP_CONTAINS: begin
                        if (r_ins) begin
                            n_hit = 1'b1;
                        end
                    end
                    OP_BOUNDS: begin
                        if (r_idx == '0) begin
                            n_x0 = r_gx;  n_y0 = r_gy;  n_x1 = r_gr;  n_y1 = r_gb;
                        end else begin
                            n_x0 = (r_gx < r_x0) ? r_gx : r_x0;
                            n_y0 = (r_gy < r_y0) ? r_gy : r_y0;
                            n_x1 = (r_gr > r_x1) ? r_gr : r_x1;
                            n_y1 = (r_gb > r_y1) ? r_gb : r_y1;
                        end
                    end
                    OP_MOVE: begin
                        st_ctl.wr_en   = 1'b1;
                        st_ctl.wr_bank = r_act;
                        wr_addr = r_idx[AW-1:0];
                        wr_data = {sat(r_gx + r_px), sat(r_gy + r_py), r_gw, r_gh};
                    end
                    default: begin
                    end
                endcase
                if (step_done) begin
                    n_pc = '0;
                    if (r_idx + CNT_W'(1) == r_count) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_READ;
                    end
                end else begin
                    n_pc = r_pc + 2'd1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out = '0;
                    n_out.hit = r_hit;
                    if (r_op == OP_SUBTRACT || r_op == OP_INTERSECT) begin
                        n_count = r_n;
                        n_act   = !r_act;
                        n_out.region_count = 7'(r_n);
                    end else begin
                        n_out.region_count = 7'(r_count);
                    end
                    if (r_op == OP_BOUNDS && r_count != '0) begin
                        bdx = (EW+1)'(r_x1) - (EW+1)'(r_x0);
                        bdy = (EW+1)'(r_y1) - (EW+1)'(r_y0);
                        n_out.bound_left = 16'((r_x0 < S16_MIN) ? S16_MIN :
                                               ((r_x0 > S16_MAX) ? S16_MAX : r_x0));
                        n_out.bound_top  = 16'((r_y0 < S16_MIN) ? S16_MIN :
                                               ((r_y0 > S16_MAX) ? S16_MAX : r_y0));
                        n_out.bound_width  = (bdx < 0) ? 16'd0 :
                                             ((bdx > (EW+1)'(65535)) ? 16'hFFFF : 16'(bdx));
                        n_out.bound_height = (bdy < 0) ? 16'd0 :
                                             ((bdy > (EW+1)'(65535)) ? 16'hFFFF : 16'(bdy));
                    end
                    n_out.overflow = r_flag;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_act    <= 1'b0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_idx    <= '0;
            r_pc     <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_act    <= n_act;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
            r_n      <= n_n;
            r_idx    <= n_idx;
            r_pc     <= n_pc;
            r_hit    <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_px <= n_px;  r_py <= n_py;  r_rx <= n_rx;  r_ry <= n_ry;
        r_rw <= n_rw;  r_rh <= n_rh;
        r_gx <= n_gx;  r_gy <= n_gy;  r_gw <= n_gw;  r_gh <= n_gh;
        r_gr <= n_gr;  r_gb <= n_gb;
        r_il <= n_il;  r_it <= n_it;  r_ir <= n_ir;  r_ib <= n_ib;
        r_ov <= n_ov;  r_ins <= n_ins;
        r_x0 <= n_x0;  r_y0 <= n_y0;  r_x1 <= n_x1;  r_y1 <= n_y1;
        r_out <= n_out;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= MAX_C) && (r_n <= MAX_C))
        else $error("region count beyond capacity");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |=> r_flag)
        else $error("overflow flag cleared");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_ctl.wr_en && r_state == S_PUT && r_op != OP_MOVE) |-> (r_n < MAX_C))
        else $error("piece written beyond capacity");

    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented");

endmodule

`default_nettype wire

/* rtl/core/rrse_store.sv */
// Two banks of region storage, one write port and one registered read port.
// Depends on rrse_pkg for the control struct.
`default_nettype none

module rrse_store #(
    parameter int DEPTH = rrse_pkg::MAX_REGIONS_DEF,
    parameter int DW    = 64
) (
    input  wire                       i_clk,
    input  wire rrse_pkg::t_store_ctl i_ctl,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [DW-1:0]              i_wr_data,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DW-1:0]             o_rd_data
);
    import rrse_pkg::*;

    logic [DW-1:0] mem_a [DEPTH];
    logic [DW-1:0] mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.wr_bank) begin
            mem_a[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_bank) begin
            mem_b[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= i_ctl.rd_bank ? mem_b[i_rd_addr] : mem_a[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rrse_geom.sv */
// Shared geometry unit: edges, overlap window and point test for one region.
// Imports rrse_pkg; pure combinational logic.
`default_nettype none

module rrse_geom #(
    parameter int EW = 18
) (
    input  wire signed [EW-1:0] i_gx,
    input  wire signed [EW-1:0] i_gy,
    input  wire [14:0]          i_gw,
    input  wire [14:0]          i_gh,
    input  wire signed [EW-1:0] i_rx,
    input  wire signed [EW-1:0] i_ry,
    input  wire [14:0]          i_rw,
    input  wire [14:0]          i_rh,
    input  wire signed [EW-1:0] i_px,
    input  wire signed [EW-1:0] i_py,
    output logic signed [EW-1:0] o_gr,
    output logic signed [EW-1:0] o_gb,
    output logic signed [EW-1:0] o_il,
    output logic signed [EW-1:0] o_it,
    output logic signed [EW-1:0] o_ir,
    output logic signed [EW-1:0] o_ib,
    output logic                 o_ov,
    output logic                 o_inside
);
    import rrse_pkg::*;

    logic signed [EW-1:0] rr;
    logic signed [EW-1:0] rb;

    always_comb begin
        o_gr = i_gx + signed'(EW'(i_gw));
        o_gb = i_gy + signed'(EW'(i_gh));
        rr   = i_rx + signed'(EW'(i_rw));
        rb   = i_ry + signed'(EW'(i_rh));
        o_ov = !(o_gr <= i_rx || rr <= i_gx || o_gb <= i_ry || rb <= i_gy);
        o_il = (i_gx > i_rx) ? i_gx : i_rx;
        o_it = (i_gy > i_ry) ? i_gy : i_ry;
        o_ir = (o_gr < rr) ? o_gr : rr;
        o_ib = (o_gb < rb) ? o_gb : rb;
        o_inside = (i_px >= i_gx) && (i_px < o_gr) && (i_py >= i_gy) && (i_py < o_gb);
    end

endmodule

`default_nettype wire
